// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on clk, off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge
`define CHK_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// antecedent in this cycle implies consequent in the same cycle
`define CHK_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/alu8f_pkg.sv =====
// ----------------------------------------------------------------------------
// alu8f_pkg
// operation codes and flag type of the 8-bit alu with status flags
// ----------------------------------------------------------------------------
package alu8f_pkg;

	typedef logic [3:0] op_t;
	typedef logic [7:0] byte_t;

	// first member is the msb, so carry sits in bit 0
	typedef struct packed {
		logic boolean;
		logic zero;
		logic negative;
		logic carry;
	} flags_t;

	localparam op_t OP_ADD  = 4'd0;
	localparam op_t OP_ADDC = 4'd1;
	localparam op_t OP_SUB  = 4'd2;
	localparam op_t OP_XOR  = 4'd3;
	localparam op_t OP_AND  = 4'd4;
	localparam op_t OP_NOT  = 4'd5;
	localparam op_t OP_SHL  = 4'd6;
	localparam op_t OP_SHR  = 4'd7;
	localparam op_t OP_INC  = 4'd8;
	localparam op_t OP_INCC = 4'd9;
	localparam op_t OP_DEC  = 4'd10;
	localparam op_t OP_GE   = 4'd11;
	localparam op_t OP_GT   = 4'd12;
	localparam op_t OP_LE   = 4'd13;
	localparam op_t OP_LT   = 4'd14;
	localparam op_t OP_EQ   = 4'd15;

	localparam byte_t SIGN_BIT  = 8'h80;
	localparam byte_t BYTE_ONES = 8'hFF;

endpackage

// ===== rtl/core/alu8_with_flags.sv =====
// ----------------------------------------------------------------------------
// alu8_with_flags
// 8-bit alu with carry, negative, zero and boolean status flags
// ----------------------------------------------------------------------------
//
// channel   dir  tdata bits (low first)                          tuser
// s_axis    in   [7:0] operand_a, [15:8] operand_b                [3:0] operation
// m_axis    out  [7:0] result, [8] carry, [9] negative,           -
//                [10] zero, [11] bool, [15:12] zero fill
//
// one word per cycle sustained while the output is not stalled; output valid
// rises once a word has passed the input register and the result register
// the flag registers update when a word moves into the result register, so
// the next word sees them with no bubble
// reset clears valids and all four flags; a stalled output word holds and
// the input side keeps taking words until both registers are full
//
module alu8_with_flags (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [7:0] operand_a, [15:8] operand_b
	input  logic [3:0]  s_axis_tuser,   // [3:0] operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // [7:0] result, [8] carry, [9] negative,
	                                    // [10] zero, [11] bool, [15:12] zero
);

	// input register
	logic                valid_s1;
	alu8f_pkg::byte_t    a_s1;
	alu8f_pkg::byte_t    b_s1;
	alu8f_pkg::op_t      op_s1;

	// result register
	logic                valid_s2;
	alu8f_pkg::byte_t    res_s2;
	alu8f_pkg::flags_t   flags_s2;

	// architectural flags carried between operations
	alu8f_pkg::flags_t   flags_q;

	alu8f_pkg::byte_t    exec_res;
	alu8f_pkg::flags_t   exec_flags;

	logic                s_fire;
	logic                advance;

	// result register frees up when empty or being drained this cycle
	assign advance       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			a_s1  <= s_axis_tdata[7:0];
			b_s1  <= s_axis_tdata[15:8];
			op_s1 <= s_axis_tuser;
		end
	end

	alu8f_exec u_exec (
		.a         (a_s1),
		.b         (b_s1),
		.op        (op_s1),
		.flags_cur (flags_q),
		.res       (exec_res),
		.flags_nxt (exec_flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			flags_q  <= '0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				flags_q <= exec_flags;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2   <= exec_res;
			flags_s2 <= exec_flags;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {4'b0000, flags_s2, res_s2};

endmodule

// ===== rtl/core/alu8f_exec.sv =====
// ----------------------------------------------------------------------------
// alu8f_exec
// combinational datapath: result and next flags from operands and old flags
// ----------------------------------------------------------------------------
module alu8f_exec (
	input  alu8f_pkg::byte_t  a,
	input  alu8f_pkg::byte_t  b,
	input  alu8f_pkg::op_t    op,
	input  alu8f_pkg::flags_t flags_cur,
	output alu8f_pkg::byte_t  res,
	output alu8f_pkg::flags_t flags_nxt
);

	logic [8:0]        sum;
	alu8f_pkg::byte_t  arith_res;
	logic              arith_cy;
	logic              is_cmp;
	logic              cmp_bit;
	logic              big_shift;

	assign sum       = {1'b0, a} + {1'b0, b};
	assign big_shift = |b[7:3];

	always_comb begin
		arith_res = '0;
		arith_cy  = 1'b0;
		is_cmp    = 1'b0;
		cmp_bit   = 1'b0;
		unique case (op)
			alu8f_pkg::OP_ADD:  arith_res = sum[7:0];
			alu8f_pkg::OP_ADDC: begin
				arith_res = sum[7:0];
				arith_cy  = sum[8];
			end
			alu8f_pkg::OP_SUB:  arith_res = a - b;
			alu8f_pkg::OP_XOR:  arith_res = a ^ b;
			alu8f_pkg::OP_AND:  arith_res = a & b;
			alu8f_pkg::OP_NOT:  arith_res = ~a;
			alu8f_pkg::OP_SHL:  arith_res = big_shift ? '0 : (a << b[2:0]);
			alu8f_pkg::OP_SHR:  arith_res = big_shift ? '0 : (a >> b[2:0]);
			alu8f_pkg::OP_INC:  arith_res = a + 8'd1;
			alu8f_pkg::OP_INCC: begin
				arith_res = a + 8'd1;
				arith_cy  = (a == alu8f_pkg::BYTE_ONES);
			end
			alu8f_pkg::OP_DEC:  arith_res = a - 8'd1;
			alu8f_pkg::OP_GE: begin
				is_cmp  = 1'b1;
				cmp_bit = (a >= b);
			end
			alu8f_pkg::OP_GT: begin
				is_cmp  = 1'b1;
				cmp_bit = (a > b);
			end
			alu8f_pkg::OP_LE: begin
				is_cmp  = 1'b1;
				cmp_bit = (a <= b);
			end
			alu8f_pkg::OP_LT: begin
				is_cmp  = 1'b1;
				cmp_bit = (a < b);
			end
			alu8f_pkg::OP_EQ: begin
				is_cmp  = 1'b1;
				cmp_bit = (a == b);
			end
		endcase
	end

	// compares keep carry, negative and zero and give a zero result
	always_comb begin
		if (is_cmp) begin
			res               = '0;
			flags_nxt         = flags_cur;
			flags_nxt.boolean = cmp_bit;
		end else begin
			res                = arith_res;
			flags_nxt.carry    = arith_cy;
			flags_nxt.negative = |(arith_res & alu8f_pkg::SIGN_BIT);
			flags_nxt.zero     = (arith_res == '0);
			flags_nxt.boolean  = 1'b0;
		end
	end

endmodule

// ===== rtl/core/alu8f_checker.sv =====
// ----------------------------------------------------------------------------
// alu8f_checker
// port-level checks of the alu output word, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module alu8f_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	logic [7:0] out_res;
	logic       out_neg;
	logic       out_zero;
	logic       out_bool;
	logic       out_stall;
	logic       res_nz;

	assign out_res   = m_axis_tdata[7:0];
	assign out_neg   = m_axis_tdata[9];
	assign out_zero  = m_axis_tdata[10];
	assign out_bool  = m_axis_tdata[11];
	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign res_nz    = |out_res;

	// a stalled output word stays put
	`CHK_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata), "stalled word changed")

	// a true compare always comes with a zero result
	`CHK_SAME(a_bool_zero_res, m_axis_tvalid && out_bool, out_res == 8'h00, "bool flag with result")

	// a nonzero result is arithmetic: zero and bool flags both clear
	`CHK_SAME(a_nonzero_flags, m_axis_tvalid && res_nz, !out_zero && !out_bool, "nonzero with flag")

	// result sign bit shows up as the negative flag
	`CHK_SAME(a_sign_neg, m_axis_tvalid && out_res[7], out_neg, "bit 7 without negative flag")

	// an empty output side never blocks the input
	`CHK_SAME(a_ready_empty, !m_axis_tvalid, s_axis_tready, "input blocked with output empty")

endmodule

bind alu8_with_flags alu8f_checker u_alu8f_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
